/* sv/grid_nearest_point_search_assert.svh */
// assertion macros for the grid nearest point search block
// used by the port checker; expects clk_i and rst_ni in scope
`ifndef GRID_NEAREST_POINT_SEARCH_ASSERT_SVH
`define GRID_NEAREST_POINT_SEARCH_ASSERT_SVH

// same-cycle implication
`define GNPS_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// next-cycle implication
`define GNPS_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

/* sv/gnps_pkg.sv */
// shared types, constants and helpers of the grid nearest point search block
// no dependencies
package gnps_pkg;

  localparam int GRID_DIM   = 64;
  localparam int CELL_LOG2  = 18;
  localparam int MAP_HALF   = 8388608;
  localparam int MAX_POINTS = 4096;

  localparam int XW    = 24;               // coordinate width
  localparam int RANGEW = 23;              // range width
  localparam int IDXW  = 12;               // result index width
  localparam int DW    = XW + 1;           // coordinate difference width
  localparam int SQW   = 2 * DW - 1;       // square of a difference
  localparam int CW    = $clog2(GRID_DIM); // cell coordinate width
  localparam int NCELL = GRID_DIM * GRID_DIM;
  localparam int CAW   = $clog2(NCELL);
  localparam int PW    = $clog2(MAX_POINTS);
  localparam int CNTW  = $clog2(MAX_POINTS + 1);

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [XW-1:0]    pos_x;
    logic signed [XW-1:0]    pos_y;
    logic [RANGEW-1:0]       max_range;
  } gnps_in_t;

  typedef struct packed {
    logic            found;
    logic [IDXW-1:0] point_index;
    logic            rejected;
  } gnps_out_t;

  // coordinate to cell, clamped at both grid edges
  function automatic logic [CW-1:0] to_cell(logic signed [XW-1:0] c);
    logic signed [XW+1:0] s;
    logic [XW+1:0]        q;
    s = (XW+2)'(c) + (XW+2)'(MAP_HALF);
    if (s < 0) begin
      q = '0;
    end else begin
      q = $unsigned(s) >> CELL_LOG2;
    end
    if (q > (XW+2)'(GRID_DIM - 1)) begin
      q = (XW+2)'(GRID_DIM - 1);
    end
    return q[CW-1:0];
  endfunction

endpackage

/* sv/grid_nearest_point_search.sv */
// top level of the grid nearest point search block
// depends on gnps_pkg and gnps_sq
//
//  channel   | ports                   | handshake
//  ----------+-------------------------+------------------------------------
//  command   | start_i, cmd_i, busy_o  | word taken when start_i && !busy_o
//  result    | done_o, res_o           | word valid for the one done_o cycle
//
// clear: sweeps every grid cell (4096 for a 64x64 grid), result at the end
// insert: S_INS_RD, S_INS_WR; full store or unused kind: answered in S_IDLE
// query: range square (S_Q_RSQ, S_Q_RSQ2), S_RING per ring, S_ROW per row,
//   S_CELL, S_CELL_CHK per visited cell, S_PT_RD..S_PT_CMP per point through
//   the shared squarer; after reset the cell occupancy memory is swept with
// busy_o high; the receiver cannot stall: each result stands for one cycle only
module grid_nearest_point_search import gnps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  gnps_in_t  cmd_i,
  output logic      busy_o,
  output logic      done_o,
  output gnps_out_t res_o
);

  localparam int RW   = CW + 1;                 // ring counter
  localparam int SW   = RW + 2;                 // signed cell arithmetic
  localparam int MRW  = RANGEW + 2;             // ring limit
  localparam int DSW  = SQW + 1;                // squared distance
  localparam int R2W  = 2 * RW + 2 * CELL_LOG2; // squared ring distance
  localparam int CMPW = (R2W > DSW) ? R2W : DSW;

  typedef enum logic [3:0] {
    S_IDLE, S_SWEEP, S_INS_RD, S_INS_WR, S_Q_RSQ, S_Q_RSQ2, S_RING, S_ROW,
    S_CELL, S_CELL_CHK, S_PT_RD, S_PT_DX, S_PT_DY, S_PT_CMP
  } state_e;

  state_e               state_q, state_d;
  logic [CAW-1:0]       sweep_q, sweep_d;
  logic                 emit_q, emit_d;
  logic [CNTW-1:0]      cnt_q, cnt_d;
  logic signed [XW-1:0] x_q, x_d, y_q, y_d;
  logic [CW-1:0]        cx_q, cx_d, cy_q, cy_d;
  logic [MRW-1:0]       mring_q, mring_d;
  logic [RW-1:0]        ring_q, ring_d;
  logic [CW-1:0]        gx_q, gx_d, gy_q, gy_d;
  logic [PW-1:0]        p_q, p_d, tail_q, tail_d, bidx_q, bidx_d;
  logic                 have_q, have_d;
  logic [DSW-1:0]       best_q, best_d;
  logic [SQW-1:0]       rsq_q, rsq_d, dxsq_q, dxsq_d;
  logic                 done_q, done_d;
  gnps_out_t            res_q, res_d;
  logic [RANGEW-1:0]    range_q;

  // memories
  logic                 occ_mem [NCELL];
  logic [PW-1:0]        head_mem [NCELL];
  logic [PW-1:0]        tail_mem [NCELL];
  logic [PW-1:0]        link_mem [MAX_POINTS];
  logic signed [XW-1:0] px_mem [MAX_POINTS];
  logic signed [XW-1:0] py_mem [MAX_POINTS];

  logic                 occ_rd;
  logic [PW-1:0]        head_rd, tail_rd, link_rd;
  logic signed [XW-1:0] px_rd, py_rd;

  logic                 cell_re, pt_re, pt_we;
  logic                 occ_we, occ_wd, head_we, tail_we, link_we;
  logic [CAW-1:0]       cell_ra, cell_wa;

  // shared squarer
  logic signed [DW-1:0] sq_a;
  logic [SQW-1:0]       sq_out;

  gnps_sq u_sq (
    .clk_i (clk_i),
    .a_i   (sq_a),
    .sq_o  (sq_out)
  );

  // ring geometry
  logic signed [SW-1:0] cx_s, cy_s, r_s, gx_s, gy_s, lim_s;
  logic signed [SW-1:0] lo_x, hi_x, lo_y, hi_y, lox, hix, loy, hiy;
  logic                 border_row, last_row;
  logic [CW-1:0]        extent;
  logic [RW-1:0]        rm1;
  logic [2*RW-1:0]      rm1_sq;
  logic [CMPW-1:0]      rmd2;
  logic [DSW-1:0]       pt_dist;
  logic                 accept, full;

  function automatic logic [CAW-1:0] cell_addr(logic [CW-1:0] gx, logic [CW-1:0] gy);
    return CAW'(CAW'(gy) * CAW'(GRID_DIM) + CAW'(gx));
  endfunction

  assign accept = start_i && (state_q == S_IDLE);
  assign full   = (cnt_q >= CNTW'(MAX_POINTS));

  always_comb begin
    cx_s  = $signed(SW'(cx_q));
    cy_s  = $signed(SW'(cy_q));
    r_s   = $signed(SW'(ring_q));
    gx_s  = $signed(SW'(gx_q));
    gy_s  = $signed(SW'(gy_q));
    lim_s = $signed(SW'(GRID_DIM - 1));
    lo_x  = cx_s - r_s;
    hi_x  = cx_s + r_s;
    lo_y  = cy_s - r_s;
    hi_y  = cy_s + r_s;
    lox   = (lo_x < 0) ? '0 : lo_x;
    hix   = (hi_x > lim_s) ? lim_s : hi_x;
    loy   = (lo_y < 0) ? '0 : lo_y;
    hiy   = (hi_y > lim_s) ? lim_s : hi_y;
    border_row = (gy_s == lo_y) || (gy_s == hi_y);
    last_row   = (gy_s == hiy);
  end

  // farthest grid edge from the query cell
  always_comb begin
    logic [CW-1:0] ex, ey;
    ex = (cx_q > CW'(GRID_DIM - 1) - cx_q) ? cx_q : CW'(GRID_DIM - 1) - cx_q;
    ey = (cy_q > CW'(GRID_DIM - 1) - cy_q) ? cy_q : CW'(GRID_DIM - 1) - cy_q;
    extent = (ex > ey) ? ex : ey;
  end

  // squared inner distance of the ring, ((ring-1) << CELL_LOG2)^2;
  // it never reaches 2^32 before the square for this grid size
  assign rm1    = ring_q - RW'(1);
  assign rm1_sq = rm1 * rm1;
  assign rmd2   = CMPW'(rm1_sq) << (2 * CELL_LOG2);

  assign pt_dist = DSW'(dxsq_q) + DSW'(sq_out);

  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    emit_d  = emit_q;
    cnt_d   = cnt_q;
    x_d     = x_q;
    y_d     = y_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    mring_d = mring_q;
    ring_d  = ring_q;
    gx_d    = gx_q;
    gy_d    = gy_q;
    p_d     = p_q;
    tail_d  = tail_q;
    bidx_d  = bidx_q;
    have_d  = have_q;
    best_d  = best_q;
    rsq_d   = rsq_q;
    dxsq_d  = dxsq_q;
    done_d  = 1'b0;
    res_d   = '0;
    sq_a    = '0;
    cell_re = 1'b0;
    pt_re   = 1'b0;
    pt_we   = 1'b0;
    occ_we  = 1'b0;
    occ_wd  = 1'b0;
    head_we = 1'b0;
    tail_we = 1'b0;
    link_we = 1'b0;
    cell_ra = cell_addr(gx_q, gy_q);
    cell_wa = cell_addr(cx_q, cy_q);

    unique case (state_q) inside
      S_IDLE: begin
        if (accept) begin
          x_d     = cmd_i.pos_x;
          y_d     = cmd_i.pos_y;
          cx_d    = to_cell(cmd_i.pos_x);
          cy_d    = to_cell(cmd_i.pos_y);
          mring_d = MRW'((MRW'(cmd_i.max_range) + MRW'((1 << CELL_LOG2) - 1)) >> CELL_LOG2)
                    + MRW'(1);
          unique case (cmd_i.kind)
            KIND_CLEAR: begin
              cnt_d   = '0;
              sweep_d = '0;
              emit_d  = 1'b1;
              state_d = S_SWEEP;
            end
            KIND_INSERT: begin
              if (full) begin
                done_d         = 1'b1;
                res_d.rejected = 1'b1;
              end else begin
                pt_we   = 1'b1;
                state_d = S_INS_RD;
              end
            end
            KIND_QUERY: begin
              state_d = S_Q_RSQ;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_SWEEP: begin
        occ_we  = 1'b1;
        cell_wa = sweep_q;
        if (sweep_q == CAW'(NCELL - 1)) begin
          done_d  = emit_q;
          state_d = S_IDLE;
        end else begin
          sweep_d = sweep_q + CAW'(1);
        end
      end
      S_INS_RD: begin
        cell_re = 1'b1;
        cell_ra = cell_addr(cx_q, cy_q);
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        tail_we = 1'b1;
        if (occ_rd) begin
          link_we = 1'b1;
        end else begin
          head_we = 1'b1;
          occ_we  = 1'b1;
          occ_wd  = 1'b1;
        end
        cnt_d             = cnt_q + CNTW'(1);
        done_d            = 1'b1;
        res_d.point_index = IDXW'(cnt_q[PW-1:0]);
        state_d           = S_IDLE;
      end
      S_Q_RSQ: begin
        sq_a    = $signed(DW'(range_q));
        state_d = S_Q_RSQ2;
      end
      S_Q_RSQ2: begin
        rsq_d   = sq_out;
        ring_d  = '0;
        have_d  = 1'b0;
        best_d  = '0;
        bidx_d  = '0;
        state_d = S_RING;
      end
      S_RING: begin
        if ((MRW'(ring_q) > mring_q) || (ring_q > RW'(extent)) ||
            ((ring_q != '0) && have_q && (rmd2 > CMPW'(best_q)))) begin
          done_d            = 1'b1;
          res_d.found       = have_q;
          res_d.point_index = have_q ? IDXW'(bidx_q) : '0;
          state_d           = S_IDLE;
        end else begin
          gy_d    = CW'(loy);
          state_d = S_ROW;
        end
      end
      S_ROW: begin
        if (border_row) begin
          gx_d    = CW'(lox);
          state_d = S_CELL;
        end else if (lo_x >= 0) begin
          gx_d    = CW'(lo_x);
          state_d = S_CELL;
        end else if (hi_x <= lim_s) begin
          gx_d    = CW'(hi_x);
          state_d = S_CELL;
        end else if (last_row) begin
          ring_d  = ring_q + RW'(1);
          state_d = S_RING;
        end else begin
          gy_d = gy_q + CW'(1);
        end
      end
      S_CELL: begin
        cell_re = 1'b1;
        state_d = S_CELL_CHK;
      end
      S_CELL_CHK, S_PT_CMP: begin
        if ((state_q == S_PT_CMP) &&
            ((!have_q || pt_dist < best_q) && pt_dist <= DSW'(rsq_q))) begin
          have_d = 1'b1;
          best_d = pt_dist;
          bidx_d = p_q;
        end
        if ((state_q == S_CELL_CHK) && occ_rd) begin
          p_d     = head_rd;
          tail_d  = tail_rd;
          state_d = S_PT_RD;
        end else if ((state_q == S_PT_CMP) && (p_q != tail_q)) begin
          p_d     = link_rd;
          state_d = S_PT_RD;
        end else if (border_row && (gx_s < hix)) begin
          // next cell along a border row
          gx_d    = gx_q + CW'(1);
          state_d = S_CELL;
        end else if (!border_row && (gx_s == lo_x) && (hi_x <= lim_s)) begin
          // inner row: jump to the right border cell
          gx_d    = CW'(hi_x);
          state_d = S_CELL;
        end else if (last_row) begin
          ring_d  = ring_q + RW'(1);
          state_d = S_RING;
        end else begin
          gy_d    = gy_q + CW'(1);
          state_d = S_ROW;
        end
      end
      S_PT_RD: begin
        pt_re   = 1'b1;
        state_d = S_PT_DX;
      end
      S_PT_DX: begin
        sq_a    = DW'(px_rd) - DW'(x_q);
        state_d = S_PT_DY;
      end
      S_PT_DY: begin
        dxsq_d  = sq_out;
        sq_a    = DW'(py_rd) - DW'(y_q);
        state_d = S_PT_CMP;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // query radius as a squarer operand
  always_ff @(posedge clk_i) begin
    if (accept) begin
      range_q <= cmd_i.max_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      sweep_q <= '0;
      emit_q  <= 1'b0;
      cnt_q   <= '0;
      ring_q  <= '0;
      have_q  <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      emit_q  <= emit_d;
      cnt_q   <= cnt_d;
      ring_q  <= ring_d;
      have_q  <= have_d;
      done_q  <= done_d;
      res_q   <= res_d;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    mring_q <= mring_d;
    gx_q    <= gx_d;
    gy_q    <= gy_d;
    p_q     <= p_d;
    tail_q  <= tail_d;
    bidx_q  <= bidx_d;
    best_q  <= best_d;
    rsq_q   <= rsq_d;
    dxsq_q  <= dxsq_d;
  end

  // cell memories: one address for reads, one for writes
  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[cell_wa] <= occ_wd;
    end
    if (cell_re) begin
      occ_rd <= occ_mem[cell_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[cell_wa] <= cnt_q[PW-1:0];
    end
    if (cell_re) begin
      head_rd <= head_mem[cell_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_we) begin
      tail_mem[cell_wa] <= cnt_q[PW-1:0];
    end
    if (cell_re) begin
      tail_rd <= tail_mem[cell_ra];
    end
  end

  // point memories
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[tail_rd] <= cnt_q[PW-1:0];
    end
    if (pt_re) begin
      link_rd <= link_mem[p_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      px_mem[cnt_q[PW-1:0]] <= cmd_i.pos_x;
    end
    if (pt_re) begin
      px_rd <= px_mem[p_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      py_mem[cnt_q[PW-1:0]] <= cmd_i.pos_y;
    end
    if (pt_re) begin
      py_rd <= py_mem[p_q];
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* sv/gnps_sq.sv */
// shared squaring unit of the grid nearest point search block
// depends on gnps_pkg
module gnps_sq import gnps_pkg::*; (
  input  logic                 clk_i,
  input  logic signed [DW-1:0] a_i,
  output logic [SQW-1:0]       sq_o
);

  logic signed [2*DW-1:0] prod;

  assign prod = a_i * a_i;

  always_ff @(posedge clk_i) begin
    sq_o <= SQW'($unsigned(prod));
  end

endmodule

/* sv/gnps_checker.sv */
// port-level checker for the grid nearest point search block, with its bind
// depends on gnps_pkg and grid_nearest_point_search_assert.svh
`include "grid_nearest_point_search_assert.svh"

module gnps_checker import gnps_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input gnps_in_t  cmd_i,
  input logic      busy_o,
  input logic      done_o,
  input gnps_out_t res_o
);

  // an accepted word either starts work or answers at once
  `GNPS_ASSERT_NEXT(a_accept_moves, start_i && !busy_o, busy_o || done_o, "accepted word lost")

  // a result only follows work or an accepted word
  `GNPS_ASSERT_NOW(a_no_spurious, done_o, $past(busy_o) || $past(start_i), "result from nowhere")

  // a refused insert carries nothing else
  `GNPS_ASSERT_NOW(a_reject_clean, done_o && res_o.rejected,
    !res_o.found && (res_o.point_index == '0), "rejected result not clean")

  // a hit is never a refusal
  `GNPS_ASSERT_NOW(a_found_not_rej, done_o && res_o.found, !res_o.rejected, "found and rejected")

endmodule

bind grid_nearest_point_search gnps_checker u_gnps_checker (.*);

/* tb/testbench.sv */
// self-checking testbench for the grid nearest point search block
// depends on gnps_pkg and the block's rtl; predicts every result word in a scoreboard class
`timescale 1ns / 1ps

module testbench;
  import gnps_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 50;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int SPREAD_ITEMS   = 200;

  // scoreboard: its own copy of the point store and cell lists, and the
  // queue of result words still owed by the block
  class nearest_scoreboard;
    int          pt_x [MAX_POINTS];
    int          pt_y [MAX_POINTS];
    int unsigned pt_next [MAX_POINTS];
    int unsigned head_of [NCELL];
    int unsigned tail_of [NCELL];
    bit          occupied [NCELL];
    int unsigned stored;
    gnps_out_t   owed [$];
    int          errors;

    // clamp a coordinate into its grid column or row
    function automatic longint cell_of(longint c);
      longint s;
      s = c + MAP_HALF;
      if (s < 0) s = 0;
      s = s >>> CELL_LOG2;
      if (s > GRID_DIM - 1) s = GRID_DIM - 1;
      return s;
    endfunction

    function automatic gnps_out_t nearest_result(gnps_in_t c);
      gnps_out_t   r;
      longint      x, y, cx, cy, extent, ring, gx, gy, lox, hix, loy, hiy;
      longint      dx, dy, rmd, dsq, best, range, range_sq, max_ring;
      int unsigned cell_no, p, idx;
      bit          have, walking;
      r = '0;
      x = c.pos_x;
      y = c.pos_y;
      cx = cell_of(x);
      cy = cell_of(y);
      case (c.kind)
        KIND_CLEAR: begin
          foreach (occupied[i]) occupied[i] = 0;
          stored = 0;
        end
        KIND_INSERT: begin
          if (stored >= MAX_POINTS) begin
            r.rejected = 1'b1;
          end else begin
            idx = stored;
            pt_x[idx] = int'(x);
            pt_y[idx] = int'(y);
            cell_no = int'(cy) * GRID_DIM + int'(cx);
            if (occupied[cell_no]) begin
              pt_next[tail_of[cell_no]] = idx;
              tail_of[cell_no] = idx;
            end else begin
              head_of[cell_no] = idx;
              tail_of[cell_no] = idx;
              occupied[cell_no] = 1;
            end
            stored = idx + 1;
            r.point_index = idx[IDXW-1:0];
          end
        end
        KIND_QUERY: begin
          have = 0;
          best = 0;
          idx = 0;
          range = c.max_range;
          range_sq = range * range;
          max_ring = ((range + (64'd1 << CELL_LOG2) - 1) >> CELL_LOG2) + 1;
          extent = cx;
          if (GRID_DIM - 1 - cx > extent) extent = GRID_DIM - 1 - cx;
          if (cy > extent) extent = cy;
          if (GRID_DIM - 1 - cy > extent) extent = GRID_DIM - 1 - cy;
          for (ring = 0; ring <= max_ring && ring <= extent; ring++) begin
            // stop once the whole ring lies beyond the best distance so far
            if (ring > 0 && have) begin
              rmd = (ring - 1) << CELL_LOG2;
              if (rmd * rmd > best) break;
            end
            lox = (cx - ring < 0) ? 0 : cx - ring;
            hix = (cx + ring > GRID_DIM - 1) ? GRID_DIM - 1 : cx + ring;
            loy = (cy - ring < 0) ? 0 : cy - ring;
            hiy = (cy + ring > GRID_DIM - 1) ? GRID_DIM - 1 : cy + ring;
            for (gy = loy; gy <= hiy; gy++) begin
              for (gx = lox; gx <= hix; gx++) begin
                // border cells of the ring only
                if ((gx - cx != ring && cx - gx != ring) &&
                    (gy - cy != ring && cy - gy != ring)) continue;
                cell_no = int'(gy) * GRID_DIM + int'(gx);
                if (!occupied[cell_no]) continue;
                p = head_of[cell_no];
                walking = 1;
                while (walking) begin
                  dx = longint'(pt_x[p]) - x;
                  dy = longint'(pt_y[p]) - y;
                  dsq = dx * dx + dy * dy;
                  if ((!have || dsq < best) && dsq <= range_sq) begin
                    have = 1;
                    best = dsq;
                    idx = p;
                  end
                  if (p == tail_of[cell_no]) walking = 0;
                  else p = pt_next[p];
                end
              end
            end
          end
          if (have) begin
            r.found = 1'b1;
            r.point_index = idx[IDXW-1:0];
          end
        end
        default: ;  // unused kind leaves the state alone
      endcase
      return r;
    endfunction

    function void note_command(gnps_in_t c);
      owed = {owed, nearest_result(c)};
    endfunction

    function void check_result(gnps_out_t got);
      gnps_out_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %p", $realtime, got);
        return;
      end
      want = owed.pop_front();
      if (got.found !== want.found) begin
        errors++;
        $display("%0t: found mismatch, expected %0b, actual %0b",
                 $realtime, want.found, got.found);
      end
      if (got.point_index !== want.point_index) begin
        errors++;
        $display("%0t: point_index mismatch, expected %0d, actual %0d",
                 $realtime, want.point_index, got.point_index);
      end
      if (got.rejected !== want.rejected) begin
        errors++;
        $display("%0t: rejected mismatch, expected %0b, actual %0b",
                 $realtime, want.rejected, got.rejected);
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  gnps_in_t  cmd_i = '0;
  logic      busy_o;
  logic      done_o;
  gnps_out_t res_o;

  nearest_scoreboard board = new();
  int idle_cycles = 0;

  // cluster center for well-formed point clouds
  int hub_x, hub_y;

  always #1 clk_i = ~clk_i;

  grid_nearest_point_search uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // result side: the receiver never stalls, each word lives one cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      board.check_result(res_o);
    end
  end

  // watchdog on cycles in which no word moves in either direction
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // mostly back to back, sometimes short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // present one command word and hold it until the block takes it
  task automatic send_word(logic [1:0] kind, int x, int y, int range);
    gnps_in_t c;
    int gap;
    c.kind = kind;
    c.pos_x = x[XW-1:0];
    c.pos_y = y[XW-1:0];
    c.max_range = range[RANGEW-1:0];
    start_i <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy_o);
    board.note_command(c);
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic int rand_coord();
    return $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
  endfunction

  // near the current cluster most of the time, anywhere otherwise
  function automatic int near_coord(int hub);
    longint v;
    if ($urandom_range(0, 9) < 3) return rand_coord();
    v = longint'(hub) + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return int'(v);
  endfunction

  function automatic int rand_range();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return $urandom_range(0, 1 << 19);
    if (roll < 9) return $urandom_range(0, 1 << 21);
    return $urandom_range(0, 23'h7FFFFF);
  endfunction

  initial begin
    int roll;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty store, corners, ties, exact hit, cell borders, unused kind
    send_word(KIND_QUERY, 0, 0, 23'h7FFFFF);
    send_word(KIND_INSERT, -8388608, -8388608, 0);
    send_word(KIND_INSERT, 8388607, 8388607, 0);
    send_word(KIND_INSERT, 0, 0, 0);
    send_word(KIND_INSERT, 0, 0, 0);             // duplicate: first one must win
    send_word(KIND_INSERT, 262143, -262144, 0);  // either side of a cell border
    send_word(KIND_INSERT, 262144, -262145, 0);
    send_word(KIND_QUERY, 0, 0, 0);              // exact hit at range zero
    send_word(KIND_QUERY, 1, 0, 0);              // just out of range
    send_word(KIND_QUERY, 262144, -262144, 1);
    send_word(KIND_QUERY, -8388608, -8388608, 23'h7FFFFF);
    send_word(KIND_QUERY, 8388607, 8388607, 23'h7FFFFF);
    send_word(KIND_QUERY, 8388607, -8388608, 23'h7FFFFF);
    send_word(KIND_QUERY, 4000000, 4000000, 1000);
    send_word(KIND_UNUSED, -1, -1, 23'h7FFFFF);
    send_word(KIND_QUERY, 100, 100, 200);
    send_word(KIND_CLEAR, 0, 0, 0);
    send_word(KIND_QUERY, 0, 0, 23'h7FFFFF);     // cleared store finds nothing

    // points spread over the whole map, then wide queries across it
    for (int i = 0; i < SPREAD_ITEMS; i++) begin
      send_word(KIND_INSERT, rand_coord(), rand_coord(), 0);
    end
    for (int i = 0; i < 4; i++) begin
      send_word(KIND_QUERY, rand_coord(), rand_coord(), rand_range());
    end
    send_word(KIND_CLEAR, rand_coord(), rand_coord(), $urandom_range(0, 23'h7FFFFF));

    // random: clustered inserts and queries, with clears and stray words
    hub_x = rand_coord();
    hub_y = rand_coord();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        send_word(KIND_CLEAR, rand_coord(), rand_coord(), $urandom_range(0, 23'h7FFFFF));
        hub_x = rand_coord();
        hub_y = rand_coord();
      end else if (roll < 7) begin
        send_word(KIND_UNUSED, rand_coord(), rand_coord(), $urandom_range(0, 23'h7FFFFF));
      end else if (roll < 52) begin
        send_word(KIND_INSERT, near_coord(hub_x), near_coord(hub_y),
                  $urandom_range(0, 23'h7FFFFF));
      end else begin
        send_word(KIND_QUERY, near_coord(hub_x), near_coord(hub_y), rand_range());
      end
    end
    start_i <= 1'b0;

    // drain the owed results, then a short quiet spell
    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
